### rtl/core/erc_pkg.sv
package erc_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned CNT_W     = 10;
    localparam int unsigned VTX_W     = 17;
    localparam int unsigned BASE_W    = 16;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned PHASE_W   = 32;
    localparam int unsigned TRIG_W    = 32;
    localparam int unsigned ARG_W     = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CNT_W-1:0]  MIN_SEGMENTS   = 10'd15;
    localparam logic [CNT_W-1:0]  MAX_SEGMENTS   = 10'd720;
    localparam logic [FRAC_W-1:0] INNER_FRAC_MAX = 16'd64880;
    localparam logic [31:0]       HALF_PI_Q30    = 32'h6487_ED51;
    localparam logic [31:0]       Q30_ONE        = 32'h4000_0000;

    localparam int unsigned HORNER_N = 5;
    localparam int unsigned HORNER_K [HORNER_N] = '{110, 72, 42, 20, 6};
    localparam int unsigned SIN_LAT = 2 + 3 * HORNER_N + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RADIUS_X,
        REG_RADIUS_Y,
        REG_INNER_FRAC,
        REG_SEGMENT_COUNT,
        REG_BASE_VERTEX
    } cfg_reg_t;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   rem;
        logic [PHASE_W-1:0] q;
    } div_t;

    typedef struct packed {
        logic             valid;
        logic             bad;
        logic [IDX_W-1:0] idx;
        logic [1:0]       quad;
    } tag_t;

endpackage

### rtl/core/erc_div_cell.sv
module erc_div_cell
    import erc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [CNT_W-1:0] cnt,
    input  div_t             d_in,
    output div_t             d_out
);

    div_t           d_reg;
    div_t           d_next;
    logic [CNT_W:0] rem2;
    logic           take;

    always_comb
    begin
        rem2   = {d_in.rem, 1'b0};
        take   = rem2 >= {1'b0, cnt};
        d_next = d_in;
        d_next.rem = take ? CNT_W'(rem2 - {1'b0, cnt}) : CNT_W'(rem2);
        d_next.q   = {d_in.q[PHASE_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

### rtl/core/erc_horner_cell.sv
module erc_horner_cell
    import erc_pkg::*;
#(
    parameter int unsigned K = 6
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [TRIG_W-1:0] x_in,
    input  logic [TRIG_W-1:0] x2_in,
    input  logic [ARG_W-1:0]  t_in,
    output logic [TRIG_W-1:0] x_out,
    output logic [TRIG_W-1:0] x2_out,
    output logic [ARG_W-1:0]  t_out
);

    localparam int unsigned SH    = 31 + $clog2(K);
    localparam logic [31:0] RECIP = 32'((64'd1 << SH) / 64'(K));

    logic [TRIG_W-1:0] y_reg, xa_reg, x2a_reg;
    logic [TRIG_W-1:0] q0_reg, yb_reg, xb_reg, x2b_reg;
    logic [ARG_W-1:0]  t_reg;
    logic [TRIG_W-1:0] xc_reg, x2c_reg;

    logic [63:0]       prod_a, prod_b;
    logic [TRIG_W-1:0] y_next, q0_next, rem, q;
    logic [ARG_W-1:0]  t_next;

    always_comb
    begin
        prod_a  = 64'(x2_in) * 64'(t_in);
        y_next  = prod_a[61:30];
        prod_b  = 64'(y_reg) * 64'(RECIP);
        q0_next = 32'(prod_b >> SH);
        rem     = yb_reg - 32'(q0_reg * 32'(K));
        q       = q0_reg + ((rem >= 32'(K)) ? 32'd1 : 32'd0);
        t_next  = ARG_W'(Q30_ONE - q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg   <= y_next;
            xa_reg  <= x_in;
            x2a_reg <= x2_in;
            q0_reg  <= q0_next;
            yb_reg  <= y_reg;
            xb_reg  <= xa_reg;
            x2b_reg <= x2a_reg;
            t_reg   <= t_next;
            xc_reg  <= xb_reg;
            x2c_reg <= x2b_reg;
        end
    end

    assign x_out  = xc_reg;
    assign x2_out = x2c_reg;
    assign t_out  = t_reg;

endmodule

### rtl/core/erc_sine.sv
module erc_sine
    import erc_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [ARG_W-1:0]  arg,
    output logic [TRIG_W-1:0] result
);

    logic [TRIG_W-1:0] x_reg, xd_reg, x2_reg, res_reg;
    logic [TRIG_W-1:0] cx  [HORNER_N+1];
    logic [TRIG_W-1:0] cx2 [HORNER_N+1];
    logic [ARG_W-1:0]  ct  [HORNER_N+1];
    logic [63:0]       p_x, p_x2, p_res;

    always_comb
    begin
        p_x   = 64'(arg) * 64'(HALF_PI_Q30);
        p_x2  = 64'(x_reg) * 64'(x_reg);
        p_res = 64'(cx[HORNER_N]) * 64'(ct[HORNER_N]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= p_x[61:30];
            xd_reg  <= x_reg;
            x2_reg  <= p_x2[61:30];
            res_reg <= p_res[61:30];
        end
    end

    assign cx[0]  = xd_reg;
    assign cx2[0] = x2_reg;
    assign ct[0]  = ARG_W'(Q30_ONE);

    for (genvar g = 0; g < HORNER_N; g++)
    begin : g_horner
        erc_horner_cell #(
            .K (HORNER_K[g])
        ) u_cell (
            .clk    (clk),
            .en     (en),
            .x_in   (cx[g]),
            .x2_in  (cx2[g]),
            .t_in   (ct[g]),
            .x_out  (cx[g+1]),
            .x2_out (cx2[g+1]),
            .t_out  (ct[g+1])
        );
    end

    assign result = res_reg;

endmodule

### rtl/core/ellipse_ring_tessellator.sv
// channel  | handshake              | payload
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
// in       | in_valid / in_stall    | segment_index
// out      | out_valid / out_stall  | outer_*, inner_*, tri_*, bad_segment
//
// one segment per cycle unless held; path: entry register, 32 restoring
// divider cells for the phase, 18-stage sine/cosine pipes, 2 scaling stages,
// output register. rst_n resets valid flags and config registers. the pipe
// keeps moving while its last stage is empty, so it takes segments while a
// result waits; it holds only if the last stage and a stalled output are full.
module ellipse_ring_tessellator
    import erc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [IDX_W-1:0]            segment_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [COORD_W-1:0]   outer_x,
    output logic signed [COORD_W-1:0]   outer_y,
    output logic signed [COORD_W-1:0]   inner_x,
    output logic signed [COORD_W-1:0]   inner_y,
    output logic [VTX_W-1:0]            tri_a0,
    output logic [VTX_W-1:0]            tri_a1,
    output logic [VTX_W-1:0]            tri_a2,
    output logic [VTX_W-1:0]            tri_b0,
    output logic [VTX_W-1:0]            tri_b1,
    output logic [VTX_W-1:0]            tri_b2,
    output logic                        bad_segment
);

    logic signed [COORD_W-1:0] center_x_reg, center_y_reg, radius_x_reg, radius_y_reg;
    logic [FRAC_W-1:0]         frac_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [BASE_W-1:0]         base_reg;
    logic [CNT_W-1:0]          cnt_next;

    logic en;
    div_t d_in_next;
    div_t d [PHASE_W+1];
    tag_t tag_d [SIN_LAT];

    logic [ARG_W-1:0]  arg_s, arg_c;
    logic [TRIG_W-1:0] sin_res, cos_res;

    tag_t              tag_q_reg, tag_p_reg;
    logic [TRIG_W-1:0] cmag_q_reg, smag_q_reg;
    logic [47:0]       cf_q_reg, sf_q_reg;
    logic              cneg_q_reg, sneg_q_reg;
    logic [TRIG_W-1:0] cmag, smag;
    logic              cneg, sneg;

    logic [COORD_W-1:0] mx, my;
    logic               rx_neg, ry_neg;
    logic [48:0]        pox_w, poy_w;
    logic [64:0]        pix_w, piy_w;
    logic [17:0]        pox_reg, poy_reg, pix_reg, piy_reg;
    logic               nx_reg, ny_reg;

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] ox_reg, oy_reg, ix_reg, iy_reg;
    logic [VTX_W-1:0]          a0_reg, a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;
    logic                      bad_reg;
    logic [VTX_W-1:0]          v0, last_vtx;
    logic                      last_seg;

    function automatic logic signed [COORD_W-1:0] coord(
        input logic signed [COORD_W-1:0] c,
        input logic [17:0]               p,
        input logic                      n
    );
        logic signed [19:0] v;
        begin
            v = 20'(c) + (n ? -$signed({2'b00, p}) : $signed({2'b00, p}));
            if (v > 20'sd32767)
                coord = 16'sh7FFF;
            else if (v < -20'sd32768)
                coord = 16'sh8000;
            else
                coord = COORD_W'(v);
        end
    endfunction

    // configuration
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data[CNT_W-1:0] < MIN_SEGMENTS)
            cnt_next = MIN_SEGMENTS;
        else if (cfg_data[CNT_W-1:0] > MAX_SEGMENTS)
            cnt_next = MAX_SEGMENTS;
        else
            cnt_next = cfg_data[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= '0;
            radius_y_reg <= '0;
            frac_reg     <= '0;
            cnt_reg      <= MIN_SEGMENTS;
            base_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:      center_x_reg <= cfg_data;
                REG_CENTER_Y:      center_y_reg <= cfg_data;
                REG_RADIUS_X:      radius_x_reg <= cfg_data;
                REG_RADIUS_Y:      radius_y_reg <= cfg_data;
                REG_INNER_FRAC:    frac_reg <= (cfg_data > INNER_FRAC_MAX) ?
                                               INNER_FRAC_MAX : cfg_data;
                REG_SEGMENT_COUNT: cnt_reg <= cnt_next;
                REG_BASE_VERTEX:   base_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // pipe advance
    assign en       = !tag_p_reg.valid || !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // entry
    always_comb
    begin
        d_in_next.valid = in_valid;
        d_in_next.bad   = segment_index >= cnt_reg;
        d_in_next.idx   = segment_index;
        d_in_next.rem   = d_in_next.bad ? '0 : segment_index;
        d_in_next.q     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d[0] <= '0;
        end
        else if (en)
        begin
            d[0] <= d_in_next;
        end
    end

    // phase = i * 2^32 / count, one quotient bit per cell
    for (genvar k = 0; k < PHASE_W; k++)
    begin : g_div
        erc_div_cell u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cnt   (cnt_reg),
            .d_in  (d[k]),
            .d_out (d[k+1])
        );
    end

    assign arg_s = {1'b0, d[PHASE_W].q[29:0]};
    assign arg_c = ARG_W'(Q30_ONE) - arg_s;

    erc_sine u_sin (
        .clk    (clk),
        .en     (en),
        .arg    (arg_s),
        .result (sin_res)
    );

    erc_sine u_cos (
        .clk    (clk),
        .en     (en),
        .arg    (arg_c),
        .result (cos_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SIN_LAT; j++)
            begin
                tag_d[j] <= '0;
            end
        end
        else if (en)
        begin
            tag_d[0] <= '{valid: d[PHASE_W].valid, bad: d[PHASE_W].bad,
                          idx: d[PHASE_W].idx, quad: d[PHASE_W].q[31:30]};
            for (int j = 1; j < SIN_LAT; j++)
            begin
                tag_d[j] <= tag_d[j-1];
            end
        end
    end

    // quadrant folding
    always_comb
    begin
        case (tag_d[SIN_LAT-1].quad)
            2'd0:
            begin
                cmag = cos_res; cneg = 1'b0; smag = sin_res; sneg = 1'b0;
            end
            2'd1:
            begin
                cmag = sin_res; cneg = 1'b1; smag = cos_res; sneg = 1'b0;
            end
            2'd2:
            begin
                cmag = cos_res; cneg = 1'b1; smag = sin_res; sneg = 1'b1;
            end
            default:
            begin
                cmag = sin_res; cneg = 1'b0; smag = cos_res; sneg = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rx_neg = radius_x_reg < 0;
        ry_neg = radius_y_reg < 0;
        mx     = rx_neg ? COORD_W'(-radius_x_reg) : COORD_W'(radius_x_reg);
        my     = ry_neg ? COORD_W'(-radius_y_reg) : COORD_W'(radius_y_reg);
        pox_w  = 49'(48'(mx) * 48'(cmag_q_reg)) + 49'(64'd1 << 29);
        poy_w  = 49'(48'(my) * 48'(smag_q_reg)) + 49'(64'd1 << 29);
        pix_w  = 65'(64'(mx) * 64'(cf_q_reg)) + 65'(64'd1 << 45);
        piy_w  = 65'(64'(my) * 64'(sf_q_reg)) + 65'(64'd1 << 45);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_q_reg <= '0;
            tag_p_reg <= '0;
        end
        else if (en)
        begin
            tag_q_reg <= tag_d[SIN_LAT-1];
            tag_p_reg <= tag_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmag_q_reg <= cmag;
            smag_q_reg <= smag;
            cneg_q_reg <= cneg;
            sneg_q_reg <= sneg;
            cf_q_reg   <= 48'(cmag) * 48'(frac_reg);
            sf_q_reg   <= 48'(smag) * 48'(frac_reg);
            pox_reg    <= 18'(pox_w >> 30);
            poy_reg    <= 18'(poy_w >> 30);
            pix_reg    <= 18'(pix_w >> 46);
            piy_reg    <= 18'(piy_w >> 46);
            nx_reg     <= rx_neg ^ cneg_q_reg;
            ny_reg     <= ry_neg ^ sneg_q_reg;
        end
    end

    // triangle indices
    always_comb
    begin
        v0       = VTX_W'(base_reg) + {tag_p_reg.idx, 1'b0};
        last_seg = tag_p_reg.idx == (cnt_reg - 10'd1);
        last_vtx = VTX_W'(base_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= tag_p_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            bad_reg <= tag_p_reg.bad;
            if (tag_p_reg.bad)
            begin
                ox_reg <= '0; oy_reg <= '0; ix_reg <= '0; iy_reg <= '0;
                a0_reg <= '0; a1_reg <= '0; a2_reg <= '0;
                b0_reg <= '0; b1_reg <= '0; b2_reg <= '0;
            end
            else
            begin
                ox_reg <= coord(center_x_reg, pox_reg, nx_reg);
                oy_reg <= coord(center_y_reg, poy_reg, ny_reg);
                ix_reg <= coord(center_x_reg, pix_reg, nx_reg);
                iy_reg <= coord(center_y_reg, piy_reg, ny_reg);
                a0_reg <= v0;
                a1_reg <= v0 + 17'd1;
                a2_reg <= last_seg ? last_vtx + 17'd1 : v0 + 17'd3;
                b0_reg <= v0;
                b1_reg <= last_seg ? last_vtx + 17'd1 : v0 + 17'd3;
                b2_reg <= last_seg ? last_vtx : v0 + 17'd2;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign outer_x     = ox_reg;
    assign outer_y     = oy_reg;
    assign inner_x     = ix_reg;
    assign inner_y     = iy_reg;
    assign tri_a0      = a0_reg;
    assign tri_a1      = a1_reg;
    assign tri_a2      = a2_reg;
    assign tri_b0      = b0_reg;
    assign tri_b1      = b1_reg;
    assign tri_b2      = b2_reg;
    assign bad_segment = bad_reg;

endmodule

### tb/sv/ellipse_ring_tessellator_tb.sv
`timescale 1ns / 1ps

module ellipse_ring_tessellator_tb;
    import erc_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] ix;
        logic signed [COORD_W-1:0] iy;
        logic [VTX_W-1:0]          a0;
        logic [VTX_W-1:0]          a1;
        logic [VTX_W-1:0]          a2;
        logic [VTX_W-1:0]          b0;
        logic [VTX_W-1:0]          b1;
        logic [VTX_W-1:0]          b2;
        logic                      bad;
    } segment_out_t;

    localparam int LATENCY = 54;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [IDX_W-1:0] segment_index;
    logic out_valid;
    logic out_stall;
    logic signed [COORD_W-1:0] outer_x, outer_y, inner_x, inner_y;
    logic [VTX_W-1:0] tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2;
    logic bad_segment;

    ellipse_ring_tessellator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .segment_index(segment_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .outer_x(outer_x), .outer_y(outer_y), .inner_x(inner_x), .inner_y(inner_y),
        .tri_a0(tri_a0), .tri_a1(tri_a1), .tri_a2(tri_a2),
        .tri_b0(tri_b0), .tri_b1(tri_b1), .tri_b2(tri_b2),
        .bad_segment(bad_segment)
    );

    // ring geometry held by the predictor
    logic signed [15:0] ring_cx, ring_cy, ring_rx, ring_ry;
    logic [15:0] ring_frac;
    logic [9:0] ring_count;
    logic [15:0] ring_base;

    segment_out_t expected_segments[$];
    int errors;
    bit stim_done;
    bit hold_off;

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #400ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [63:0] sine_q30(logic [63:0] r);
        logic [63:0] x, x2, t;
        x = (r * 64'h6487ED51) >> 30;
        x2 = (x * x) >> 30;
        t = (64'd1 << 30) - x2 / 110;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    function automatic longint scale_round(longint a, logic [63:0] m, bit neg, int sh);
        bit n;
        logic [63:0] mag, p;
        n = (a < 0) != neg;
        mag = (a < 0) ? -a : a;
        p = (mag * m + (64'd1 << (sh - 1))) >> sh;
        return n ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [15:0] clamp_coord(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic segment_out_t tessellate(logic [9:0] i);
        segment_out_t s;
        logic [63:0] phase, r, sa, ca, cm, sm;
        bit cn, sn;
        logic [16:0] b;
        s = '0;
        if (i >= ring_count)
        begin
            s.bad = 1'b1;
            return s;
        end
        phase = (64'(i) << 32) / ring_count;
        r = phase & ((64'd1 << 30) - 1);
        sa = sine_q30(r);
        ca = sine_q30((64'd1 << 30) - r);
        case (phase[31:30])
            2'd0:
            begin
                cm = ca; cn = 0; sm = sa; sn = 0;
            end
            2'd1:
            begin
                cm = sa; cn = 1; sm = ca; sn = 0;
            end
            2'd2:
            begin
                cm = ca; cn = 1; sm = sa; sn = 1;
            end
            default:
            begin
                cm = sa; cn = 0; sm = ca; sn = 1;
            end
        endcase
        s.ox = clamp_coord(ring_cx + scale_round(ring_rx, cm, cn, 30));
        s.oy = clamp_coord(ring_cy + scale_round(ring_ry, sm, sn, 30));
        s.ix = clamp_coord(ring_cx + scale_round(ring_rx, cm * ring_frac, cn, 46));
        s.iy = clamp_coord(ring_cy + scale_round(ring_ry, sm * ring_frac, sn, 46));
        b = ring_base;
        s.a0 = b + 2 * i;
        s.a1 = b + 2 * i + 1;
        s.a2 = b + 2 * i + 3;
        s.b0 = b + 2 * i;
        s.b1 = b + 2 * i + 3;
        s.b2 = b + 2 * i + 2;
        if (i == ring_count - 1)
        begin
            s.a2 = b + 1;
            s.b1 = b + 1;
            s.b2 = b;
        end
        return s;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_CENTER_X: ring_cx = val;
            REG_CENTER_Y: ring_cy = val;
            REG_RADIUS_X: ring_rx = val;
            REG_RADIUS_Y: ring_ry = val;
            REG_INNER_FRAC: ring_frac = (val > INNER_FRAC_MAX) ? INNER_FRAC_MAX : val;
            REG_SEGMENT_COUNT:
            begin
                ring_count = (val[9:0] < MIN_SEGMENTS) ? MIN_SEGMENTS :
                             (val[9:0] > MAX_SEGMENTS) ? MAX_SEGMENTS : val[9:0];
            end
            default: ring_base = val;
        endcase
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // has_exp: row carries a hand-read expectation checked against the predictor
    task automatic send_segment(logic [9:0] i, bit has_exp, segment_out_t exp_row);
        segment_out_t p;
        p = tessellate(i);
        if (has_exp && p !== exp_row)
        begin
            $display("%0t table row idx %0d expected %h actual %h", $time, i, exp_row, p);
            errors++;
        end
        in_valid <= 1'b1;
        segment_index <= i;
        do @(posedge clk); while (in_stall);
        expected_segments.push_back(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_segments.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic check_field(string name, logic signed [31:0] exp_v,
                               logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // receiver
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                segment_out_t got;
                segment_out_t exp_s;
                got = '{outer_x, outer_y, inner_x, inner_y, tri_a0, tri_a1, tri_a2,
                        tri_b0, tri_b1, tri_b2, bad_segment};
                if (expected_segments.size() == 0)
                begin
                    $display("%0t unexpected transfer, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp_s = expected_segments.pop_front();
                    check_field("outer_x", exp_s.ox, got.ox);
                    check_field("outer_y", exp_s.oy, got.oy);
                    check_field("inner_x", exp_s.ix, got.ix);
                    check_field("inner_y", exp_s.iy, got.iy);
                    check_field("tri_a0", exp_s.a0, got.a0);
                    check_field("tri_a1", exp_s.a1, got.a1);
                    check_field("tri_a2", exp_s.a2, got.a2);
                    check_field("tri_b0", exp_s.b0, got.b0);
                    check_field("tri_b1", exp_s.b1, got.b1);
                    check_field("tri_b2", exp_s.b2, got.b2);
                    check_field("bad_segment", exp_s.bad, got.bad);
                end
            end
            if (hold_off) out_stall <= 1'b1;
            else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
            else if ($urandom_range(0, 3) == 0 && !stim_done) out_stall <= ($urandom_range(0, 1) == 1);
            else out_stall <= 1'b0;
        end
    end

    typedef struct {
        logic [9:0] idx;
        bit has_exp;
        segment_out_t exp_row;
    } stim_row_t;

    initial
    begin
        stim_row_t rows[$];
        segment_out_t z;
        int n;
        errors = 0;
        stim_done = 0;
        hold_off = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        in_valid = 1'b0;
        segment_index = '0;
        ring_cx = 0; ring_cy = 0; ring_rx = 0; ring_ry = 0;
        ring_frac = 0; ring_count = MIN_SEGMENTS; ring_base = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: zero radius, count 15, base 0
        z = '0;
        z.a0 = 0; z.a1 = 1; z.a2 = 3; z.b0 = 0; z.b1 = 3; z.b2 = 2;
        rows.push_back('{10'd0, 1, z});
        z = '0;
        z.a0 = 28; z.a1 = 29; z.a2 = 1; z.b0 = 28; z.b1 = 1; z.b2 = 0;
        rows.push_back('{10'd14, 1, z});
        z = '0; z.bad = 1;
        rows.push_back('{10'd15, 1, z});
        rows.push_back('{10'd1023, 1, z});
        rows.push_back('{10'd7, 0, z});
        foreach (rows[k]) send_segment(rows[k].idx, rows[k].has_exp, rows[k].exp_row);
        drain();

        // extremes: full radii, max and min center, clamped fraction and counts
        write_reg(REG_CENTER_X, 16'h7fff);
        write_reg(REG_CENTER_Y, 16'h8000);
        write_reg(REG_RADIUS_X, 16'h7fff);
        write_reg(REG_RADIUS_Y, 16'h8000);
        write_reg(REG_INNER_FRAC, 16'hffff);
        write_reg(REG_SEGMENT_COUNT, 16'd3);
        write_reg(REG_BASE_VERTEX, 16'hffff);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 16; i++) send_segment(10'(i), 0, '0);
        drain();
        write_reg(REG_CENTER_X, 16'h0000);
        write_reg(REG_CENTER_Y, 16'h0000);
        write_reg(REG_SEGMENT_COUNT, 16'h3ff);
        write_reg(REG_RADIUS_Y, 16'h7fff);
        cfg_valid <= 1'b0;
        send_segment(10'd0, 0, '0);
        send_segment(10'd180, 0, '0);
        send_segment(10'd360, 0, '0);
        send_segment(10'd540, 0, '0);
        send_segment(10'd719, 0, '0);
        send_segment(10'd720, 0, '0);
        drain();

        for (int phase_n = 0; phase_n < 8; phase_n++)
        begin
            write_reg(REG_CENTER_X, 16'($urandom));
            write_reg(REG_CENTER_Y, 16'($urandom));
            write_reg(REG_RADIUS_X, 16'($urandom));
            write_reg(REG_RADIUS_Y, 16'($urandom));
            write_reg(REG_INNER_FRAC,
                      ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom));
            case ($urandom_range(0, 3))
                0: write_reg(REG_SEGMENT_COUNT, 16'd15);
                1: write_reg(REG_SEGMENT_COUNT, 16'd720);
                default: write_reg(REG_SEGMENT_COUNT, 16'($urandom_range(0, 1023)));
            endcase
            write_reg(REG_BASE_VERTEX, 16'($urandom));
            cfg_valid <= 1'b0;
            if (phase_n == 3)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int k = 0; k < 235; k++)
            begin
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1023);
                else if ($urandom_range(0, 9) == 0) n = ring_count - 1;
                else n = $urandom_range(0, ring_count - 1);
                send_segment(10'(n), 0, '0);
                if (phase_n != 3) idle_gap();
            end
            drain();
        end

        stim_done = 1;
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
